/* rtl/lpc_pkg.sv */
// lpc_pkg: shared types and default constants for the pointwise LSTM cell.
// No dependencies; imported by lpc_pwl_act and lstm_pointwise_cell.
package lpc_pkg;

   // Default datapath format: Q3.12 in 16 bits.
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;

   // Piecewise-linear activation selector.
   typedef enum logic {
      ACT_SIGMOID = 1'b0,
      ACT_TANH    = 1'b1
   } act_mode_type;

endpackage

/* rtl/lpc_pwl_act.sv */
// lpc_pwl_act: piecewise-linear sigmoid or tanh (tanh = 2*sigmoid(2x) - 1).
// Depends on lpc_pkg for act_mode_type.
module lpc_pwl_act
   import lpc_pkg::*;
#(
   parameter int           IN_WIDTH  = DATA_WIDTH_DEF,
   parameter int           FRAC_BITS = FRAC_BITS_DEF,
   parameter act_mode_type MODE      = ACT_SIGMOID
) (
   input  logic signed [IN_WIDTH-1:0]  x,
   output logic signed [FRAC_BITS+1:0] y
);

   localparam int XW = IN_WIDTH + 1;
   localparam int CW = ((XW > FRAC_BITS + 4) ? XW : FRAC_BITS + 4) + 1;
   localparam int YW = FRAC_BITS + 1;

   localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
   localparam logic [CW-1:0] T_HI = CW'(5) << FRAC_BITS;
   localparam logic [CW-1:0] T_MD = (CW'(19) << FRAC_BITS) >> 3;
   localparam logic [CW-1:0] K_HI = (CW'(27) << FRAC_BITS) >> 5;
   localparam logic [CW-1:0] K_MD = (CW'(5) << FRAC_BITS) >> 3;
   localparam logic [CW-1:0] K_LO = ONE >> 1;

   logic signed [XW-1:0] xs;
   logic signed [CW-1:0] xw;
   logic [CW-1:0]        mag;
   logic [CW-1:0]        seg;
   logic [YW-1:0]        sig;

   always_comb begin
      // tanh takes sigmoid of 2x, formed without loss
      if (MODE == ACT_TANH) begin
         xs = {x, 1'b0};
      end else begin
         xs = XW'(x);
      end
      xw  = CW'(xs);
      mag = xw[CW-1] ? CW'(-xw) : CW'(xw);

      if (mag >= T_HI) begin
         seg = ONE;
      end else if (mag >= T_MD) begin
         seg = (mag >> 5) + K_HI;
      end else if (mag >= ONE) begin
         seg = (mag >> 3) + K_MD;
      end else begin
         seg = (mag >> 2) + K_LO;
      end

      // mirror around one half for negative inputs
      sig = xw[CW-1] ? YW'(ONE - seg) : YW'(seg);

      if (MODE == ACT_TANH) begin
         y = $signed({sig, 1'b0}) - $signed((FRAC_BITS + 2)'(ONE));
      end else begin
         y = $signed({1'b0, sig});
      end
   end

endmodule

/* rtl/lpc_round_sat.sv */
// lpc_round_sat: round a wide product sum to FRAC_BITS (ties up) and saturate.
// No package dependencies.
module lpc_round_sat #(
   parameter int IN_WIDTH   = 32,
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic signed [IN_WIDTH-1:0]   p,
   output logic signed [DATA_WIDTH-1:0] q
);

   localparam int SW = IN_WIDTH + 1 - FRAC_BITS;

   localparam logic signed [SW-1:0] Q_MAX = SW'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
   localparam logic signed [SW-1:0] Q_MIN = -Q_MAX - SW'(1);
   localparam logic signed [IN_WIDTH:0] HALF = (IN_WIDTH + 1)'(1) << (FRAC_BITS - 1);

   logic signed [IN_WIDTH:0] biased;
   logic signed [IN_WIDTH:0] shifted;
   logic signed [SW-1:0]     whole;

   always_comb begin
      biased  = (IN_WIDTH + 1)'(p) + HALF;
      shifted = biased >>> FRAC_BITS;
      whole   = shifted[SW-1:0];
      if (whole > Q_MAX) begin
         q = Q_MAX[DATA_WIDTH-1:0];
      end else if (whole < Q_MIN) begin
         q = Q_MIN[DATA_WIDTH-1:0];
      end else begin
         q = whole[DATA_WIDTH-1:0];
      end
   end

endmodule

/* rtl/lstm_pointwise_cell.sv */
// Pointwise LSTM cell: one hidden element per beat, c = i*g + f*c_prev and
// h = o*tanh(c) in signed fixed point. A new beat can be taken every clock while
// req_tready is high, which drops only when every stage is full and rsp_tready is
// low; each beat passes seven register stages (bias add, gate activations, gate
// products, cell round/saturate, tanh of the cell, output product, output
// round/saturate), and the result beat waits in the last stage for rsp_tready. Each
// stage holds when the stage after it is full and stalled, so empty stages still
// fill while a result waits on rsp_tready.
// forget_bias resets to 1.0 and is written through csr_wr_en/csr_wr_data.
// Depends on lpc_pkg, lpc_pwl_act and lpc_round_sat.
module lstm_pointwise_cell
   import lpc_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int REQ_W = ((5 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // lowest bit up: pre_input_gate, pre_forget_gate, pre_output_gate,
   // pre_candidate, cell_prev, zero fill
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // lowest bit up: cell_next, hidden_out, zero fill
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [DATA_WIDTH-1:0] csr_wr_data
);

   localparam int DW = DATA_WIDTH;
   localparam int GW = FRAC_BITS + 2;
   localparam int IGW = 2 * GW;
   localparam int FCW = GW + DW;
   localparam int PW = ((IGW > FCW) ? IGW : FCW) + 1;
   localparam int NS = 7;

   localparam logic signed [DW:0] SUM_MAX = (DW + 1)'((64'(1) << (DW - 1)) - 64'(1));
   localparam logic signed [DW:0] SUM_MIN = -SUM_MAX - (DW + 1)'(1);

   // stage valids and advance enables
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   logic signed [DW-1:0] forget_bias_ff;

   // stage 1
   logic signed [DW-1:0] s1_pi_ff, s1_fb_ff, s1_po_ff, s1_pg_ff, s1_cp_ff;
   logic signed [DW:0]   fb_sum;
   logic signed [DW-1:0] fb_in;
   // stage 2
   logic signed [GW-1:0] gi_in, gf_in, go_in, gg_in;
   logic signed [GW-1:0] s2_gi_ff, s2_gf_ff, s2_go_ff, s2_gg_ff;
   logic signed [DW-1:0] s2_cp_ff;
   // stage 3
   logic signed [IGW-1:0] s3_ig_ff;
   logic signed [FCW-1:0] s3_fc_ff;
   logic signed [GW-1:0]  s3_go_ff;
   // stage 4
   logic signed [PW-1:0]  cell_sum;
   logic signed [DW-1:0]  cell_in;
   logic signed [DW-1:0]  s4_c_ff;
   logic signed [GW-1:0]  s4_go_ff;
   // stage 5
   logic signed [GW-1:0]  tc_in;
   logic signed [GW-1:0]  s5_tc_ff, s5_go_ff;
   logic signed [DW-1:0]  s5_c_ff;
   // stage 6
   logic signed [IGW-1:0] s6_oh_ff;
   logic signed [DW-1:0]  s6_c_ff;
   // stage 7
   logic signed [DW-1:0]  hid_in;
   logic signed [DW-1:0]  s7_h_ff, s7_c_ff;

   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = RSP_W'({s7_h_ff, s7_c_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff         <= '0;
         forget_bias_ff <= DW'(64'(1) << FRAC_BITS);
      end else begin
         if (csr_wr_en) begin
            forget_bias_ff <= csr_wr_data;
         end
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // stage 1: unpack and add the forget bias with saturation
   always_comb begin
      fb_sum = (DW + 1)'($signed(req_tdata[2*DW-1:DW])) + (DW + 1)'(forget_bias_ff);
      if (fb_sum > SUM_MAX) begin
         fb_in = SUM_MAX[DW-1:0];
      end else if (fb_sum < SUM_MIN) begin
         fb_in = SUM_MIN[DW-1:0];
      end else begin
         fb_in = fb_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_pi_ff <= req_tdata[DW-1:0];
         s1_fb_ff <= fb_in;
         s1_po_ff <= req_tdata[3*DW-1:2*DW];
         s1_pg_ff <= req_tdata[4*DW-1:3*DW];
         s1_cp_ff <= req_tdata[5*DW-1:4*DW];
      end
   end

   // stage 2: gate activations
   lpc_pwl_act #(.IN_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .MODE(ACT_SIGMOID)) u_act_i (
      .x(s1_pi_ff), .y(gi_in)
   );
   lpc_pwl_act #(.IN_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .MODE(ACT_SIGMOID)) u_act_f (
      .x(s1_fb_ff), .y(gf_in)
   );
   lpc_pwl_act #(.IN_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .MODE(ACT_SIGMOID)) u_act_o (
      .x(s1_po_ff), .y(go_in)
   );
   lpc_pwl_act #(.IN_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .MODE(ACT_TANH)) u_act_g (
      .x(s1_pg_ff), .y(gg_in)
   );

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_gi_ff <= gi_in;
         s2_gf_ff <= gf_in;
         s2_go_ff <= go_in;
         s2_gg_ff <= gg_in;
         s2_cp_ff <= s1_cp_ff;
      end
   end

   // stage 3: gate products
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_ig_ff <= IGW'(s2_gi_ff) * IGW'(s2_gg_ff);
         s3_fc_ff <= FCW'(s2_gf_ff) * FCW'(s2_cp_ff);
         s3_go_ff <= s2_go_ff;
      end
   end

   // stage 4: exact sum, single rounding, saturate
   assign cell_sum = PW'(s3_ig_ff) + PW'(s3_fc_ff);

   lpc_round_sat #(.IN_WIDTH(PW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_rs_cell (
      .p(cell_sum), .q(cell_in)
   );

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_c_ff  <= cell_in;
         s4_go_ff <= s3_go_ff;
      end
   end

   // stage 5: tanh of the new cell value
   lpc_pwl_act #(.IN_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .MODE(ACT_TANH)) u_act_c (
      .x(s4_c_ff), .y(tc_in)
   );

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_tc_ff <= tc_in;
         s5_go_ff <= s4_go_ff;
         s5_c_ff  <= s4_c_ff;
      end
   end

   // stage 6: output gate product
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_oh_ff <= IGW'(s5_go_ff) * IGW'(s5_tc_ff);
         s6_c_ff  <= s5_c_ff;
      end
   end

   // stage 7: round and saturate the hidden value, hold for the output side
   lpc_round_sat #(.IN_WIDTH(PW), .DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_rs_hid (
      .p(PW'(s6_oh_ff)), .q(hid_in)
   );

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_h_ff <= hid_in;
         s7_c_ff <= s6_c_ff;
      end
   end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for lstm_pointwise_cell, directed table then random beats,
// each result compared against a built-in Q3.12 gate/cell predictor with random stalls.
// Depends on lpc_pkg and the lstm_pointwise_cell RTL.
module tb_top;
   import lpc_pkg::*;

   localparam int  DW        = DATA_WIDTH_DEF;
   localparam int  FB        = FRAC_BITS_DEF;
   localparam int  REQ_W     = ((5 * DW + 7) / 8) * 8;
   localparam int  RSP_W     = ((2 * DW + 7) / 8) * 8;
   localparam int  LAT_PAD   = 12;
   localparam int  HOLD_LEN  = 400;
   localparam int  IDLE_MAX  = 4000;
   localparam int  SHOW_MAX  = 10;
   localparam longint ONE    = longint'(1) <<< FB;
   localparam longint FX_MAX = (longint'(1) <<< (DW - 1)) - 1;
   localparam longint FX_MIN = -FX_MAX - 1;
   localparam int  KNEES[7]  = '{20480, 9728, 4096, 10240, 4864, 2048, 0};

   typedef logic signed [DW-1:0] fx_type;

   typedef struct {
      fx_type pre_i;
      fx_type pre_f;
      fx_type pre_o;
      fx_type pre_g;
      fx_type c_prev;
   } gate_beat_type;

   typedef struct {
      fx_type c_next;
      fx_type h_out;
   } cell_res_type;

   typedef struct {
      gate_beat_type stim;
      bit            known;
      cell_res_type  want;
   } dir_row_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [DW-1:0]    csr_wr_data = '0;

   fx_type       fbias;
   cell_res_type expected_q[$];
   dir_row_type  dir_rows[$];
   int           fail_count   = 0;
   int           idle_cycles  = 0;
   int           holds_wanted = 0;
   int           holds_done   = 0;
   int           rdy_wait     = 0;
   bit           no_idle      = 1'b0;

   lstm_pointwise_cell u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint sat_fx(longint v);
      if (v > FX_MAX) return FX_MAX;
      if (v < FX_MIN) return FX_MIN;
      return v;
   endfunction

   // round to nearest, ties toward plus infinity; >>> on longint floors
   function automatic longint round_frac(longint p);
      return (p + (ONE >>> 1)) >>> FB;
   endfunction

   function automatic longint sigmoid_pwl(longint x);
      longint a;
      longint y;
      a = (x < 0) ? -x : x;
      if (a >= 5 * ONE)
         y = ONE;
      else if (a >= ((19 * ONE) >>> 3))
         y = (a >>> 5) + ((27 * ONE) >>> 5);
      else if (a >= ONE)
         y = (a >>> 3) + ((5 * ONE) >>> 3);
      else
         y = (a >>> 2) + (ONE >>> 1);
      return (x < 0) ? ONE - y : y;
   endfunction

   function automatic longint tanh_pwl(longint x);
      return 2 * sigmoid_pwl(2 * x) - ONE;
   endfunction

   function automatic cell_res_type predict_cell(gate_beat_type b);
      longint       f_sum;
      longint       gi;
      longint       gf;
      longint       go;
      longint       gg;
      longint       c;
      longint       h;
      cell_res_type r;
      f_sum = sat_fx(longint'(b.pre_f) + longint'(fbias));
      gi = sigmoid_pwl(longint'(b.pre_i));
      gf = sigmoid_pwl(f_sum);
      go = sigmoid_pwl(longint'(b.pre_o));
      gg = tanh_pwl(longint'(b.pre_g));
      c  = sat_fx(round_frac(gi * gg + gf * longint'(b.c_prev)));
      h  = sat_fx(round_frac(go * tanh_pwl(c)));
      r.c_next = fx_type'(c);
      r.h_out  = fx_type'(h);
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic add_row(int pi, int pf, int po, int pg, int cp,
                          bit known = 1'b0, int wc = 0, int wh = 0);
      dir_row_type row;
      row.stim.pre_i  = fx_type'(pi);
      row.stim.pre_f  = fx_type'(pf);
      row.stim.pre_o  = fx_type'(po);
      row.stim.pre_g  = fx_type'(pg);
      row.stim.c_prev = fx_type'(cp);
      row.known       = known;
      row.want.c_next = fx_type'(wc);
      row.want.h_out  = fx_type'(wh);
      dir_rows.push_back(row);
   endtask

   // mostly realistic values, plus full-range noise, extremes and knee points
   function automatic fx_type rand_field();
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         v = $urandom_range(0, 65535);
      end else if (pick == 4) begin
         v = KNEES[$urandom_range(0, 6)] + $urandom_range(0, 2) - 1;
         if ($urandom_range(0, 1)) v = -v;
      end else if (pick == 5) begin
         v = $urandom_range(0, 1) ? 32767 : -32768;
      end else begin
         v = $urandom_range(0, 16384) - 8192;
      end
      return fx_type'(v);
   endfunction

   task automatic offer_beat(gate_beat_type b, cell_res_type want);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 25) begin
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {b.c_prev, b.pre_g, b.pre_o, b.pre_f, b.pre_i};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(want);
   endtask

   // drop valid, wait for every result, then let the pipeline run dry
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   task automatic write_bias(fx_type v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fbias = v;
      @(posedge clock);
   endtask

   task automatic run_random(int n, int busy_first);
      gate_beat_type b;
      for (int i = 0; i < n; i++) begin
         if (i < busy_first)
            no_idle = 1'b1;
         else if ((i - busy_first) % 100 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         b.pre_i  = rand_field();
         b.pre_f  = rand_field();
         b.pre_o  = rand_field();
         b.pre_g  = rand_field();
         b.c_prev = rand_field();
         offer_beat(b, predict_cell(b));
      end
      settle();
   endtask

   // ---------------- main sequence ----------------
   initial begin
      fbias = fx_type'(4096);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero, all max, all min, gates driven to opposite rails
      add_row(0, 0, 0, 0, 0, 1'b1, 0, 0);
      add_row(32767, 32767, 32767, 32767, 32767, 1'b1, 32767, 4096);
      add_row(-32768, -32768, -32768, -32768, -32768, 1'b1, 0, 0);
      add_row(32767, -32768, 32767, 32767, 0, 1'b1, 4096, 3072);
      // half-LSB ties on the cell rounding, both signs
      add_row(0, -4096, 0, 0, 1, 1'b1, 1, 0);
      add_row(0, -4096, 0, 0, -1, 1'b1, 0, 0);
      // negative cell saturation
      add_row(32767, 32767, 0, -32768, -32768);
      // sigmoid knees on the input gate
      add_row(20480, 0, 4096, 4096, 0);
      add_row(20479, 0, 4096, 4096, 0);
      add_row(-20480, 0, 4096, 4096, 0);
      add_row(-20479, 0, 4096, 4096, 0);
      add_row(9728, 0, 4096, 4096, 0);
      add_row(9727, 0, 4096, 4096, 0);
      add_row(-9728, 0, 4096, 4096, 0);
      add_row(4096, 0, 4096, 4096, 0);
      add_row(4095, 0, 4096, 4096, 0);
      add_row(-4096, 0, 4096, 4096, 0);
      add_row(-4095, 0, 4096, 4096, 0);
      // tanh knees on the candidate gate (doubled input)
      add_row(32767, 0, 32767, 10240, 0);
      add_row(32767, 0, 32767, 10239, 0);
      add_row(32767, 0, 32767, 4864, 0);
      add_row(32767, 0, 32767, 4863, 0);
      add_row(32767, 0, 32767, 2048, 0);
      add_row(32767, 0, 32767, 2047, 0);
      add_row(32767, 0, 32767, -2048, 0);

      foreach (dir_rows[k])
         offer_beat(dir_rows[k].stim,
                    dir_rows[k].known ? dir_rows[k].want : predict_cell(dir_rows[k].stim));
      settle();

      // most negative bias, with a long output stall while input keeps coming
      write_bias(fx_type'(-32768));
      holds_wanted = holds_wanted + 1;
      run_random(300, 80);

      write_bias(fx_type'(32767));
      run_random(300, 0);

      write_bias(fx_type'(0));
      run_random(300, 0);

      for (int p = 0; p < 4; p++) begin
         write_bias(fx_type'($urandom_range(0, 65535)));
         run_random(100, 0);
      end

      repeat (LAT_PAD) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ---------------- output side ready ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rdy_wait   <= 0;
      end else if (rdy_wait != 0) begin
         rdy_wait   <= rdy_wait - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_wanted) begin
         holds_done <= holds_done + 1;
         rdy_wait   <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         rdy_wait   <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(15, 50);
         rsp_tready <= 1'b0;
      end
   end

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      cell_res_type want;
      fx_type       got_c;
      fx_type       got_h;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_c = rsp_tdata[DW-1:0];
         got_h = rsp_tdata[2*DW-1:DW];
         if (expected_q.size() == 0) begin
            if (fail_count < SHOW_MAX)
               $display("unexpected result beat: cell_next %0d hidden_out %0d", got_c, got_h);
            fail_count = fail_count + 1;
         end else begin
            want = expected_q.pop_front();
            if (got_c !== want.c_next || got_h !== want.h_out) begin
               if (fail_count < SHOW_MAX)
                  $display("mismatch: cell_next exp %0d got %0d, hidden_out exp %0d got %0d",
                           want.c_next, got_c, want.h_out, got_h);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
